// File: src/qrr_pkg.sv
// ----------------------------------------------------------------------------
// qrr_pkg: shared definitions for the quadratic real root pipeline
// Status codes and the fixed widths of the result fields.
// ----------------------------------------------------------------------------
package qrr_pkg;

   localparam int ROOT_BITS = 29;
   localparam int STATUS_BITS = 2;
   localparam int OUT_TDATA_BITS = ((ROOT_BITS + 7) / 8) * 8;

   typedef logic [STATUS_BITS-1:0] status_type;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_A_ZERO  = 2'd1;
   localparam status_type STATUS_NO_ROOT = 2'd2;

endpackage

// File: src/qrr_sqrt_step.sv
// ----------------------------------------------------------------------------
// qrr_sqrt_step: one registered digit step of the integer square root
// Takes the next two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module qrr_sqrt_step #(
   parameter int RAD_W  = 58,
   parameter int ROOT_W = 29,
   parameter int SIDE_W = 35
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_rad,
   input  logic [ROOT_W+1:0] in_rem,
   input  logic [ROOT_W-1:0] in_root,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [RAD_W-1:0]  out_rad,
   output logic [ROOT_W+1:0] out_rem,
   output logic [ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff;
   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W+1:0] rem_ff, rem_in, rem_shift, trial;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [SIDE_W-1:0] side_ff;

   // The remainder never exceeds twice the partial root, so its top two bits
   // are free before the shift.
   always_comb begin
      rem_shift = {in_rem[ROOT_W-1:0], in_rad[RAD_W-1 -: 2]};
      trial     = {in_root, 2'b01};
      if (rem_shift >= trial) begin
         rem_in  = rem_shift - trial;
         root_in = {in_root[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_shift;
         root_in = {in_root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rad_ff  <= in_rad << 2;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

// File: src/qrr_div_step.sv
// ----------------------------------------------------------------------------
// qrr_div_step: one registered step of a restoring unsigned divider
// Quotient bits shift into the low end of the dividend register.
// ----------------------------------------------------------------------------
module qrr_div_step #(
   parameter int NUM_W  = 30,
   parameter int DIV_W  = 17,
   parameter int SIDE_W = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_dvd,
   input  logic [DIV_W-1:0]  in_rem,
   input  logic [DIV_W-1:0]  in_dsr,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_dvd,
   output logic [DIV_W-1:0]  out_rem,
   output logic [DIV_W-1:0]  out_dsr,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff;
   logic [NUM_W-1:0]  dvd_ff;
   logic [DIV_W-1:0]  rem_ff, rem_in, rem_shift, dsr_ff;
   logic [SIDE_W-1:0] side_ff;
   logic              qbit;

   always_comb begin
      rem_shift = {in_rem[DIV_W-2:0], in_dvd[NUM_W-1]};
      qbit      = (rem_shift >= in_dsr);
      rem_in    = qbit ? rem_shift - in_dsr : rem_shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dvd_ff  <= {in_dvd[NUM_W-2:0], qbit};
         rem_ff  <= rem_in;
         dsr_ff  <= in_dsr;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_dvd   = dvd_ff;
   assign out_rem   = rem_ff;
   assign out_dsr   = dsr_ff;
   assign out_side  = side_ff;

endmodule

// File: src/quadratic_real_root.sv
// ----------------------------------------------------------------------------
// quadratic_real_root: one real root of a*x*x + b*x + c in fixed point
// Discriminant, digit-serial square root and restoring divide, all pipelined.
//
//   channel   direction  tdata                     tuser
//   req_*     in         coef_a, coef_b, coef_c    func
//   rsp_*     out        root_value                status
//
// One request enters per cycle while the response is not stalled. Each square
// root stage decides one root digit and each divider stage one quotient bit.
// Reset clears only the stage valid bits. A stalled response holds the whole
// pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quadratic_real_root import qrr_pkg::*; #(
   parameter int COEF_BITS = 16,
   parameter int FRAC_BITS = 12
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // coef_a, coef_b, coef_c, zero fill
   input  logic [((3*COEF_BITS+7)/8)*8-1:0]         req_tdata,
   // func
   input  logic                                     req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // root_value, zero fill
   output logic [OUT_TDATA_BITS-1:0]                rsp_tdata,
   // status
   output status_type                               rsp_tuser
);

   localparam int CB      = COEF_BITS;
   localparam int DISC_W  = 2*CB + 1;
   localparam int RAD_RAW = DISC_W + 2*FRAC_BITS;
   localparam int RAD_W   = RAD_RAW + (RAD_RAW % 2);
   localparam int ROOT_W  = RAD_W / 2;
   localparam int BSH_W   = CB - 1 + FRAC_BITS;
   localparam int NUM_W   = ((BSH_W > ROOT_W) ? BSH_W : ROOT_W) + 1;
   localparam int DIV_W   = CB + 1;
   localparam int SIDE_W  = 2*CB + 3;
   localparam int QS_W    = 3;

   logic enable;

   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   // Input register.
   logic                 s1_valid_ff;
   logic signed [CB-1:0] s1_a_ff, s1_b_ff, s1_c_ff;
   logic                 s1_func_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_a_ff    <= req_tdata[CB-1:0];
         s1_b_ff    <= req_tdata[2*CB-1:CB];
         s1_c_ff    <= req_tdata[3*CB-1:2*CB];
         s1_func_ff <= req_tuser;
      end
   end

   // Products.
   logic                   s2_valid_ff;
   logic signed [2*CB-1:0] s2_bsq_ff, s2_ac_ff;
   logic signed [CB-1:0]   s2_a_ff, s2_b_ff;
   logic                   s2_func_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (enable) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s2_bsq_ff  <= s1_b_ff * s1_b_ff;
         s2_ac_ff   <= s1_a_ff * s1_c_ff;
         s2_a_ff    <= s1_a_ff;
         s2_b_ff    <= s1_b_ff;
         s2_func_ff <= s1_func_ff;
      end
   end

   // Discriminant and status.
   logic signed [2*CB+2:0] disc_full;
   status_type             status_in;
   logic [RAD_W-1:0]       rad_in;

   always_comb begin
      disc_full = (2*CB+3)'(s2_bsq_ff) - ((2*CB+3)'(s2_ac_ff) <<< 2);
      if (s2_a_ff == '0) begin
         status_in = STATUS_A_ZERO;
      end else if (disc_full[2*CB+2]) begin
         status_in = STATUS_NO_ROOT;
      end else begin
         status_in = STATUS_OK;
      end
      if (status_in == STATUS_OK) begin
         rad_in = RAD_W'(disc_full[DISC_W-1:0]) << (2*FRAC_BITS);
      end else begin
         rad_in = '0;
      end
   end

   logic              sq_valid [0:ROOT_W];
   logic [RAD_W-1:0]  sq_rad   [0:ROOT_W];
   logic [ROOT_W+1:0] sq_rem   [0:ROOT_W];
   logic [ROOT_W-1:0] sq_root  [0:ROOT_W];
   logic [SIDE_W-1:0] sq_side  [0:ROOT_W];

   logic              s3_valid_ff;
   logic [RAD_W-1:0]  s3_rad_ff;
   logic [SIDE_W-1:0] s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (enable) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s3_rad_ff  <= rad_in;
         s3_side_ff <= {status_in, s2_func_ff, s2_a_ff, s2_b_ff};
      end
   end

   assign sq_valid[0] = s3_valid_ff;
   assign sq_rad[0]   = s3_rad_ff;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_side[0]  = s3_side_ff;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
      qrr_sqrt_step #(
         .RAD_W  (RAD_W),
         .ROOT_W (ROOT_W),
         .SIDE_W (SIDE_W)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (sq_valid[i]),
         .in_rad    (sq_rad[i]),
         .in_rem    (sq_rem[i]),
         .in_root   (sq_root[i]),
         .in_side   (sq_side[i]),
         .out_valid (sq_valid[i+1]),
         .out_rad   (sq_rad[i+1]),
         .out_rem   (sq_rem[i+1]),
         .out_root  (sq_root[i+1]),
         .out_side  (sq_side[i+1])
      );
   end

   // Numerator -b*2^F +/- root, split into sign and magnitude for the divider.
   logic signed [CB-1:0]  nb_b, nb_a;
   logic                  nb_func;
   status_type            nb_status;
   logic signed [NUM_W:0] num_full, neg_b;
   logic [NUM_W:0]        num_abs;
   logic [DIV_W-1:0]      a_abs;

   always_comb begin
      {nb_status, nb_func, nb_a, nb_b} = sq_side[ROOT_W];
      neg_b    = -((NUM_W+1)'(nb_b) <<< FRAC_BITS);
      num_full = nb_func ? neg_b + (NUM_W+1)'(sq_root[ROOT_W])
                         : neg_b - (NUM_W+1)'(sq_root[ROOT_W]);
      num_abs  = num_full[NUM_W] ? -num_full : num_full;
      a_abs    = nb_a[CB-1] ? -DIV_W'(nb_a) : DIV_W'(nb_a);
   end

   logic              dv_valid [0:NUM_W];
   logic [NUM_W-1:0]  dv_dvd   [0:NUM_W];
   logic [DIV_W-1:0]  dv_rem   [0:NUM_W];
   logic [DIV_W-1:0]  dv_dsr   [0:NUM_W];
   logic [QS_W-1:0]   dv_side  [0:NUM_W];

   logic              s4_valid_ff;
   logic [NUM_W-1:0]  s4_dvd_ff;
   logic [DIV_W-1:0]  s4_dsr_ff;
   logic [QS_W-1:0]   s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (enable) begin
         s4_valid_ff <= sq_valid[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s4_dvd_ff  <= num_abs[NUM_W-1:0];
         s4_dsr_ff  <= a_abs << 1;
         s4_side_ff <= {nb_status, num_full[NUM_W] ^ nb_a[CB-1]};
      end
   end

   assign dv_valid[0] = s4_valid_ff;
   assign dv_dvd[0]   = s4_dvd_ff;
   assign dv_rem[0]   = '0;
   assign dv_dsr[0]   = s4_dsr_ff;
   assign dv_side[0]  = s4_side_ff;

   for (genvar j = 0; j < NUM_W; j++) begin : g_div
      qrr_div_step #(
         .NUM_W  (NUM_W),
         .DIV_W  (DIV_W),
         .SIDE_W (QS_W)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (dv_valid[j]),
         .in_dvd    (dv_dvd[j]),
         .in_rem    (dv_rem[j]),
         .in_dsr    (dv_dsr[j]),
         .in_side   (dv_side[j]),
         .out_valid (dv_valid[j+1]),
         .out_dvd   (dv_dvd[j+1]),
         .out_rem   (dv_rem[j+1]),
         .out_dsr   (dv_dsr[j+1]),
         .out_side  (dv_side[j+1])
      );
   end

   // Apply the quotient sign and mask results that carry an error status.
   status_type            q_status;
   logic                  q_neg;
   logic signed [NUM_W:0] q_signed;
   logic [ROOT_BITS-1:0]  root_in;

   always_comb begin
      {q_status, q_neg} = dv_side[NUM_W];
      q_signed = q_neg ? -$signed({1'b0, dv_dvd[NUM_W]}) : $signed({1'b0, dv_dvd[NUM_W]});
      root_in  = (q_status == STATUS_OK) ? ROOT_BITS'(q_signed) : '0;
   end

   logic                 out_valid_ff;
   logic [ROOT_BITS-1:0] out_root_ff;
   status_type           out_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= dv_valid[NUM_W];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_root_ff   <= root_in;
         out_status_ff <= q_status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OUT_TDATA_BITS'(out_root_ff);
   assign rsp_tuser  = out_status_ff;

endmodule

// File: dv/qrr_checker.sv
// ----------------------------------------------------------------------------
// qrr_checker: response checker for the quadratic real root pipeline
// Watches both stream channels, predicts the root and status of every
// accepted request and compares each response with the oldest prediction.
// ----------------------------------------------------------------------------
module qrr_checker import qrr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // coef_a, coef_b, coef_c
   input  logic [47:0] req_tdata,
   // func
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // root_value, zero fill
   input  logic [OUT_TDATA_BITS-1:0] rsp_tdata,
   // status
   input  status_type  rsp_tuser,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [ROOT_BITS-1:0] root;
      status_type           status;
   } root_result_t;

   root_result_t root_queue[$];

   // Integer square root, rounded down, of a value below 2^58.
   function automatic longint unsigned isqrt(input logic [127:0] v);
      longint unsigned r;
      logic [127:0] cand;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         cand = r | (64'd1 << i);
         if (cand * cand <= v) r = cand;
      end
      return r;
   endfunction

   function automatic root_result_t solve_root(input logic [47:0] d, input logic f);
      root_result_t res;
      longint a, b, c, num, q;
      logic signed [63:0] disc;
      longint unsigned r;
      a = longint'($signed(d[15:0]));
      b = longint'($signed(d[31:16]));
      c = longint'($signed(d[47:32]));
      res.root = '0;
      res.status = STATUS_OK;
      if (a == 0) begin
         res.status = STATUS_A_ZERO;
         return res;
      end
      disc = b * b - 4 * a * c;
      if (disc < 0) begin
         res.status = STATUS_NO_ROOT;
         return res;
      end
      r = isqrt(128'(disc) << 24);
      num = -b * 4096;
      num = f ? num + longint'(r) : num - longint'(r);
      q = num / (2 * a);
      res.root = q[ROOT_BITS-1:0];
      return res;
   endfunction

   assign pending = root_queue.size();

   always @(posedge clock) begin
      root_result_t want, got;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            root_queue.push_back(solve_root(req_tdata, req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            got.root = rsp_tdata[ROOT_BITS-1:0];
            got.status = rsp_tuser;
            if (root_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = root_queue.pop_front();
               if (want != got) begin
                  if (fail_count < 10)
                     $display("mismatch: root exp %h got %h, status exp %0d got %0d",
                              want.root, got.root, want.status, got.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the quadratic real root pipeline
// Sends directed and random coefficient sets with random gaps and response
// stalls, including one long stall that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb import qrr_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [OUT_TDATA_BITS-1:0] rsp_tdata;
   status_type rsp_tuser;
   int fail_count, pending;
   int idle_cycles = 0;
   bit long_hold = 0;

   quadratic_real_root dut (.*);
   qrr_checker checker_i (.*);

   initial forever #2 clock = ~clock;

   function automatic int gap_len();
      if ($urandom_range(9) < 5) return 0;
      if ($urandom_range(19) == 0) return $urandom_range(100, 20);
      return $urandom_range(3, 1);
   endfunction

   // Valid stays high between back-to-back requests; it drops only for a gap.
   task automatic send_coefs(input logic [15:0] a, b, c, input logic f);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {c, b, a};
      req_tuser <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_coef();
      case ($urandom_range(3))
         0: return 16'($signed($urandom_range(16)) - 8);
         1: return 16'($signed($urandom_range(512)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   // Response side: random stalls, with one long hold-off while requests keep coming.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end
         n = gap_len();
         if (n == 0) rsp_tready <= 1;
         else begin
            rsp_tready <= 0;
            repeat (n - 1) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [15:0] ext[4];
      ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
      repeat (7) @(posedge clock);
      reset <= 0;
      // Zero a, negative discriminant, zero discriminant, positive discriminant, extremes.
      send_coefs(16'd0, 16'd5, 16'd3, 1'b1);
      send_coefs(16'd1, 16'd0, 16'd1, 1'b0);
      send_coefs(16'd1, 16'hFFFC, 16'd4, 1'b0);
      send_coefs(16'd1, 16'hFFFC, 16'd4, 1'b1);
      send_coefs(16'd1, 16'hFFFD, 16'd2, 1'b1);
      send_coefs(16'd1, 16'hFFFD, 16'd2, 1'b0);
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            send_coefs(ext[i], ext[j], ext[(i + j) % 4], 1'((i ^ j) & 1));
      long_hold = 1;
      for (int k = 0; k < 1530; k++)
         send_coefs(rand_coef(), rand_coef(), rand_coef(), 1'($urandom_range(1)));
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
